/* sv/ptc_pkg.sv */
// Shared widths, register codes, calibration type and arithmetic constants.
`timescale 1ns / 1ps

package ptc_pkg;

  // Field widths
  localparam int unsigned RawW    = 24;
  localparam int unsigned CalW    = 16;
  localparam int unsigned TempW   = 13;
  localparam int unsigned PresW   = 19;
  localparam int unsigned RegIdxW = 3;

  // Number of register stages in the arithmetic pipeline.
  localparam int unsigned NumStages = 13;

  // Calibration register indexes.
  typedef enum logic [RegIdxW-1:0] {
    REG_SENS_BASE         = 3'd0,
    REG_OFFSET_BASE       = 3'd1,
    REG_SENS_TEMP_SLOPE   = 3'd2,
    REG_OFFSET_TEMP_SLOPE = 3'd3,
    REG_REF_TEMPERATURE   = 3'd4,
    REG_TEMP_SLOPE        = 3'd5
  } ptc_reg_e;

  // The six calibration words.
  typedef struct packed {
    logic [CalW-1:0] sens_base;
    logic [CalW-1:0] offset_base;
    logic [CalW-1:0] sens_temp_slope;
    logic [CalW-1:0] offset_temp_slope;
    logic [CalW-1:0] ref_temperature;
    logic [CalW-1:0] temp_slope;
  } ptc_cal_t;

  // Reference temperature of 20.00 C in hundredths.
  localparam logic signed [18:0] TempRef = 19'sd2000;
  // Very-low threshold (-15.00 C) expressed as a deviation from 20.00 C.
  localparam logic signed [17:0] VeryLowDev = -18'sd3500;

  // Reciprocals for exact truncating division: ceil(2^25/100), ceil(2^31/10).
  localparam logic [18:0] Recip100 = 19'd335545;
  localparam logic [27:0] Recip10  = 28'd214748365;

  // Pressure saturation bounds.
  localparam logic [23:0]        PresMaxMag = 24'd262143;
  localparam logic [23:0]        PresMinMag = 24'd262144;
  localparam logic signed [18:0] PresMax    = 19'sd262143;
  localparam logic signed [18:0] PresMin    = {1'b1, 18'd0};

endpackage

/* sv/ptc_if.sv */
// Stream and configuration channel interfaces for the compensation block.
`timescale 1ns / 1ps

// Raw sample pair channel.
interface ptc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptc_pkg::RawW-1:0]     raw_pressure;
  logic [ptc_pkg::RawW-1:0]     raw_temp;

  modport source (output valid, output raw_pressure, output raw_temp, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temp, output ready);
endinterface

// Compensated result channel.
interface ptc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptc_pkg::TempW-1:0]  temp_celsius;
  logic signed [ptc_pkg::PresW-1:0]  pressure_mbar;

  modport source (output valid, output temp_celsius, output pressure_mbar, input ready);
  modport sink   (input valid, input temp_celsius, input pressure_mbar, output ready);
endinterface

// Calibration register write channel.
interface ptc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptc_pkg::RegIdxW-1:0]   index;
  logic [ptc_pkg::CalW-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/pressure_temp_compensation.sv */
// Top level: calibration registers, pipeline valid/stall control and datapath.
//
// Channel   Dir  Word contents                              Notes
// sample_i  in   raw_pressure[23:0], raw_temp[23:0]         one raw pair per word
// result_o  out  temp_celsius[12:0], pressure_mbar[18:0]    signed, whole C and mbar
// cfg_i     in   index[2:0], data[15:0]                     always ready
//
// One word can be accepted every cycle while the first stage is free to load; its result leaves
// once it has passed every stage of the arithmetic pipeline (multipliers and wide
// adders each followed by a register). Reset clears the calibration words to
// zero and empties the pipeline. Each stage holds only while the stage after it
// is full and held, so empty stages keep filling while a result waits.
`timescale 1ns / 1ps

module pressure_temp_compensation (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptc_in_if.sink     sample_i,
  ptc_out_if.source  result_o,
  ptc_cfg_if.sink    cfg_i
);

  localparam int unsigned NStg = ptc_pkg::NumStages;

  ptc_pkg::ptc_cal_t cal;
  logic [NStg-1:0]   vld_d, vld_q;
  logic [NStg-1:0]   stg_en;
  logic              in_acc, out_acc;

  // Calibration register file.
  ptc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cal_o  (cal)
  );

  // A stage loads when it is empty or the stage after it moves.
  always_comb begin
    stg_en[NStg-1] = !vld_q[NStg-1] || result_o.ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    vld_d[0] = stg_en[0] ? sample_i.valid : vld_q[0];
    for (int k = 1; k < NStg; k++) begin
      vld_d[k] = stg_en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign sample_i.ready = stg_en[0];
  assign result_o.valid = vld_q[NStg-1];
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign out_acc        = result_o.valid && result_o.ready;

  // Arithmetic pipeline.
  ptc_datapath u_dp (
    .clk_i           (clk_i),
    .en_i            (stg_en),
    .cal_i           (cal),
    .raw_pressure_i  (sample_i.raw_pressure),
    .raw_temp_i      (sample_i.raw_temp),
    .temp_celsius_o  (result_o.temp_celsius),
    .pressure_mbar_o (result_o.pressure_mbar)
  );

  // The input is never blocked while the output stage is free to move.
  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!vld_q[NStg-1] || result_o.ready) |-> sample_i.ready)
    else $error("input blocked although the pipeline can drain");

  // An accepted word lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted word not captured by the first stage");

  // Occupancy changes only by accepted and delivered words.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + $past(out_acc) == $countones($past(vld_q)) + $past(in_acc)))
    else $error("pipeline lost or duplicated a word");

endmodule

/* sv/ptc_cfg_regs.sv */
// Calibration register file written through the configuration channel.
`timescale 1ns / 1ps

module ptc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptc_cfg_if.sink           cfg_i,
  output ptc_pkg::ptc_cal_t cal_o
);

  ptc_pkg::ptc_cal_t cal_d, cal_q;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (ptc_pkg::ptc_reg_e'(cfg_i.index))
        ptc_pkg::REG_SENS_BASE:         cal_d.sens_base         = cfg_i.data;
        ptc_pkg::REG_OFFSET_BASE:       cal_d.offset_base       = cfg_i.data;
        ptc_pkg::REG_SENS_TEMP_SLOPE:   cal_d.sens_temp_slope   = cfg_i.data;
        ptc_pkg::REG_OFFSET_TEMP_SLOPE: cal_d.offset_temp_slope = cfg_i.data;
        ptc_pkg::REG_REF_TEMPERATURE:   cal_d.ref_temperature   = cfg_i.data;
        ptc_pkg::REG_TEMP_SLOPE:        cal_d.temp_slope        = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

/* sv/ptc_datapath.sv */
// Thirteen-stage arithmetic pipeline for second-order compensation.
`timescale 1ns / 1ps

module ptc_datapath (
  input  logic                               clk_i,
  input  logic [ptc_pkg::NumStages-1:0]      en_i,
  input  ptc_pkg::ptc_cal_t                  cal_i,
  input  logic [ptc_pkg::RawW-1:0]           raw_pressure_i,
  input  logic [ptc_pkg::RawW-1:0]           raw_temp_i,
  output logic signed [ptc_pkg::TempW-1:0]   temp_celsius_o,
  output logic signed [ptc_pkg::PresW-1:0]   pressure_mbar_o
);

  // ---------------- Stage 1: temperature difference dT ----------------
  logic signed [24:0] s1_dt_d, s1_dt_q;
  logic [23:0]        s1_d1_q;

  assign s1_dt_d = $signed({1'b0, raw_temp_i})
                 - $signed({1'b0, cal_i.ref_temperature, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= raw_pressure_i;
    end
  end

  // ---------------- Stage 2: products with dT and dT squared ----------------
  logic signed [41:0] s2_c3dt_d, s2_c4dt_d, s2_c6dt_d;
  logic signed [41:0] s2_c3dt_q, s2_c4dt_q, s2_c6dt_q;
  logic signed [49:0] s2_dtsq_full;
  logic [47:0]        s2_dtsq_q;
  logic [23:0]        s2_d1_q;

  assign s2_c3dt_d    = $signed({1'b0, cal_i.sens_temp_slope}) * s1_dt_q;
  assign s2_c4dt_d    = $signed({1'b0, cal_i.offset_temp_slope}) * s1_dt_q;
  assign s2_c6dt_d    = $signed({1'b0, cal_i.temp_slope}) * s1_dt_q;
  assign s2_dtsq_full = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_c3dt_q <= s2_c3dt_d;
      s2_c4dt_q <= s2_c4dt_d;
      s2_c6dt_q <= s2_c6dt_d;
      s2_dtsq_q <= s2_dtsq_full[47:0];
      s2_d1_q   <= s1_d1_q;
    end
  end

  // ---------------- Stage 3: first-order sens, offset, deviation ----------------
  // Adding (2^k - 1) to a negative value before the arithmetic shift makes
  // the division truncate toward zero.
  logic signed [41:0] s3_c3_adj, s3_c4_adj, s3_c6_adj;
  logic signed [33:0] s3_sens_d, s3_sens_q;
  logic signed [34:0] s3_off_d, s3_off_q;
  logic signed [17:0] s3_dev_d, s3_dev_q;
  logic [49:0]        s3_dtsq3;
  logic [16:0]        s3_ti_lo_q;
  logic [11:0]        s3_ti_hi_q;
  logic [23:0]        s3_d1_q;

  assign s3_c3_adj = s2_c3dt_q + (s2_c3dt_q[41] ? 42'sd255 : 42'sd0);
  assign s3_c4_adj = s2_c4dt_q + (s2_c4dt_q[41] ? 42'sd127 : 42'sd0);
  assign s3_c6_adj = s2_c6dt_q + (s2_c6dt_q[41] ? 42'sd8388607 : 42'sd0);

  assign s3_sens_d = $signed({3'b000, cal_i.sens_base, 15'h0000}) + $signed(s3_c3_adj[41:8]);
  assign s3_off_d  = $signed({3'b000, cal_i.offset_base, 16'h0000}) + $signed(s3_c4_adj[41:7]);
  // The deviation from 20.00 C stays within 18 signed bits.
  assign s3_dev_d  = $signed(s3_c6_adj[40:23]);
  // 3 * dT^2 for the low branch; dT^2 is never negative so shifts truncate.
  assign s3_dtsq3  = {2'b00, s2_dtsq_q} + {1'b0, s2_dtsq_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_sens_q  <= s3_sens_d;
      s3_off_q   <= s3_off_d;
      s3_dev_q   <= s3_dev_d;
      s3_ti_lo_q <= s3_dtsq3[49:33];
      s3_ti_hi_q <= s2_dtsq_q[47:36];
      s3_d1_q    <= s2_d1_q;
    end
  end

  // ---------------- Stage 4: branch flags, squares, second-order temperature ----------------
  logic               s4_low_d, s4_vlow_d;
  logic signed [35:0] s4_devsq_full;
  logic signed [18:0] s4_vl;
  logic signed [37:0] s4_vlsq_full;
  logic [16:0]        s4_ti;
  logic signed [18:0] s4_temp2_d;
  logic               s4_low_q, s4_vlow_q;
  logic [33:0]        s4_devsq_q, s4_vlsq_q;
  logic signed [18:0] s4_temp2_q;
  logic signed [33:0] s4_sens_q;
  logic signed [34:0] s4_off_q;
  logic [23:0]        s4_d1_q;

  assign s4_low_d      = s3_dev_q[17];
  assign s4_vlow_d     = s3_dev_q < ptc_pkg::VeryLowDev;
  assign s4_devsq_full = s3_dev_q * s3_dev_q;
  // Offset from -15.00 C; its square only matters in the very-low branch.
  assign s4_vl         = $signed({s3_dev_q[17], s3_dev_q})
                       - $signed({ptc_pkg::VeryLowDev[17], ptc_pkg::VeryLowDev});
  assign s4_vlsq_full  = s4_vl * s4_vl;
  assign s4_ti         = s4_low_d ? s3_ti_lo_q : {5'b00000, s3_ti_hi_q};
  assign s4_temp2_d    = ptc_pkg::TempRef + $signed({s3_dev_q[17], s3_dev_q})
                       - $signed({2'b00, s4_ti});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_low_q   <= s4_low_d;
      s4_vlow_q  <= s4_vlow_d;
      s4_devsq_q <= s4_devsq_full[33:0];
      s4_vlsq_q  <= s4_vlsq_full[33:0];
      s4_temp2_q <= s4_temp2_d;
      s4_sens_q  <= s3_sens_q;
      s4_off_q   <= s3_off_q;
      s4_d1_q    <= s3_d1_q;
    end
  end

  // ---------------- Stage 5: second-order offset and sensitivity terms ----------------
  logic [35:0]        s5_dev3;
  logic [36:0]        s5_dev5;
  logic [36:0]        s5_vl7;
  logic [37:0]        s5_offi_d, s5_offi_q;
  logic [36:0]        s5_sensi_d, s5_sensi_q;
  logic [18:0]        s5_temp2_neg;
  logic               s5_tneg_q;
  logic [17:0]        s5_tmag_q;
  logic signed [33:0] s5_sens_q;
  logic signed [34:0] s5_off_q;
  logic [23:0]        s5_d1_q;

  assign s5_dev3 = {2'b00, s4_devsq_q} + {1'b0, s4_devsq_q, 1'b0};
  assign s5_dev5 = {1'b0, s4_devsq_q, 2'b00} + {3'b000, s4_devsq_q};
  assign s5_vl7  = {s4_vlsq_q, 3'b000} - {3'b000, s4_vlsq_q};

  always_comb begin
    if (s4_low_q) begin
      s5_offi_d  = {3'b000, s5_dev3[35:1]} + (s4_vlow_q ? {1'b0, s5_vl7} : 38'd0);
      s5_sensi_d = {3'b000, s5_dev5[36:3]} + (s4_vlow_q ? {1'b0, s4_vlsq_q, 2'b00} : 37'd0);
    end else begin
      s5_offi_d  = {8'h00, s4_devsq_q[33:4]};
      s5_sensi_d = '0;
    end
  end

  // Magnitude of the corrected temperature for the division by 100.
  assign s5_temp2_neg = -s4_temp2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_offi_q  <= s5_offi_d;
      s5_sensi_q <= s5_sensi_d;
      s5_tneg_q  <= s4_temp2_q[18];
      s5_tmag_q  <= s4_temp2_q[18] ? s5_temp2_neg[17:0] : s4_temp2_q[17:0];
      s5_sens_q  <= s4_sens_q;
      s5_off_q   <= s4_off_q;
      s5_d1_q    <= s4_d1_q;
    end
  end

  // ---------------- Stage 6: net sensitivity and offset, temperature / 100 ----------------
  logic signed [37:0] s6_sens_net_d, s6_sens_net_q;
  logic signed [38:0] s6_off_net_d, s6_off_net_q;
  logic [36:0]        s6_tprod;
  logic [11:0]        s6_tq_q;
  logic               s6_tneg_q;
  logic [23:0]        s6_d1_q;

  assign s6_sens_net_d = $signed({{4{s5_sens_q[33]}}, s5_sens_q}) - $signed({1'b0, s5_sensi_q});
  assign s6_off_net_d  = $signed({{4{s5_off_q[34]}}, s5_off_q}) - $signed({1'b0, s5_offi_q});
  assign s6_tprod      = s5_tmag_q * ptc_pkg::Recip100;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_sens_net_q <= s6_sens_net_d;
      s6_off_net_q  <= s6_off_net_d;
      s6_tq_q       <= s6_tprod[36:25];
      s6_tneg_q     <= s5_tneg_q;
      s6_d1_q       <= s5_d1_q;
    end
  end

  // ---------------- Stage 7: partial products of D1 * net sensitivity ----------------
  // The temperature quotient never exceeds 2400, so it needs no saturation.
  logic [42:0]        s7_pp_lo_d, s7_pp_lo_q;
  logic signed [43:0] s7_pp_hi_d, s7_pp_hi_q;
  logic signed [12:0] s7_temp_d, s7_temp_q;
  logic signed [38:0] s7_off_net_q;

  assign s7_pp_lo_d = s6_d1_q * s6_sens_net_q[18:0];
  assign s7_pp_hi_d = $signed({1'b0, s6_d1_q}) * $signed(s6_sens_net_q[37:19]);
  assign s7_temp_d  = s6_tneg_q ? -$signed({1'b0, s6_tq_q}) : $signed({1'b0, s6_tq_q});

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_pp_lo_q   <= s7_pp_lo_d;
      s7_pp_hi_q   <= s7_pp_hi_d;
      s7_temp_q    <= s7_temp_d;
      s7_off_net_q <= s6_off_net_q;
    end
  end

  // ---------------- Stage 8: combine partial products ----------------
  logic signed [62:0] s8_prod_d, s8_prod_q;
  logic signed [12:0] s8_temp_q;
  logic signed [38:0] s8_off_net_q;

  assign s8_prod_d = $signed({s7_pp_hi_q, 19'h00000}) + $signed({20'h00000, s7_pp_lo_q});

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s8_prod_q    <= s8_prod_d;
      s8_temp_q    <= s7_temp_q;
      s8_off_net_q <= s7_off_net_q;
    end
  end

  // ---------------- Stage 9: product / 2^21 toward zero ----------------
  logic signed [62:0] s9_adj;
  logic signed [41:0] s9_q21_q;
  logic signed [12:0] s9_temp_q;
  logic signed [38:0] s9_off_net_q;

  assign s9_adj = s8_prod_q + (s8_prod_q[62] ? 63'sd2097151 : 63'sd0);

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s9_q21_q     <= $signed(s9_adj[62:21]);
      s9_temp_q    <= s8_temp_q;
      s9_off_net_q <= s8_off_net_q;
    end
  end

  // ---------------- Stage 10: subtract net offset ----------------
  logic signed [41:0] s10_a_full;
  logic signed [40:0] s10_a_q;
  logic signed [12:0] s10_temp_q;

  assign s10_a_full = s9_q21_q - $signed({{3{s9_off_net_q[38]}}, s9_off_net_q});

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      s10_a_q    <= s10_a_full[40:0];
      s10_temp_q <= s9_temp_q;
    end
  end

  // ---------------- Stage 11: sign and magnitude ----------------
  // Truncating /8192 then /10 equals the same on the magnitude with the sign put back.
  logic [40:0]        s11_a_neg;
  logic               s11_neg_q;
  logic [39:0]        s11_amag_q;
  logic signed [12:0] s11_temp_q;

  assign s11_a_neg = -s10_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      s11_neg_q  <= s10_a_q[40];
      s11_amag_q <= s10_a_q[40] ? s11_a_neg[39:0] : s10_a_q[39:0];
      s11_temp_q <= s10_temp_q;
    end
  end

  // ---------------- Stage 12: magnitude / 8192 / 10 by reciprocal ----------------
  logic [54:0]        s12_prod;
  logic [23:0]        s12_q10_q;
  logic               s12_neg_q;
  logic signed [12:0] s12_temp_q;

  assign s12_prod = s11_amag_q[39:13] * ptc_pkg::Recip10;

  always_ff @(posedge clk_i) begin
    if (en_i[11]) begin
      s12_q10_q  <= s12_prod[54:31];
      s12_neg_q  <= s11_neg_q;
      s12_temp_q <= s11_temp_q;
    end
  end

  // ---------------- Stage 13: restore sign and saturate ----------------
  logic signed [24:0] s13_negq;
  logic signed [18:0] s13_pres_d, s13_pres_q;
  logic signed [12:0] s13_temp_q;

  assign s13_negq = -$signed({1'b0, s12_q10_q});

  always_comb begin
    if (s12_neg_q) begin
      s13_pres_d = (s12_q10_q > ptc_pkg::PresMinMag) ? ptc_pkg::PresMin : s13_negq[18:0];
    end else begin
      s13_pres_d = (s12_q10_q > ptc_pkg::PresMaxMag) ? ptc_pkg::PresMax
                                                      : $signed(s12_q10_q[18:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[12]) begin
      s13_pres_q <= s13_pres_d;
      s13_temp_q <= s12_temp_q;
    end
  end

  assign temp_celsius_o  = s13_temp_q;
  assign pressure_mbar_o = s13_pres_q;

endmodule
